/* design/znpp_pkg.sv */
// shared types, opcode constants and helpers for the z80 next-pc predictor
// no dependencies; used by znpp_decode, z80_next_pc_predictor_top and tb_top
package znpp_pkg;

    // prefix bytes
    localparam logic [7:0] PFX_DD = 8'hDD;
    localparam logic [7:0] PFX_FD = 8'hFD;
    localparam logic [7:0] PFX_CB = 8'hCB;
    localparam logic [7:0] PFX_ED = 8'hED;

    // prefix window: the opcode must appear within this many bytes
    localparam int unsigned PFX_MAX = 4;

    // plain opcodes
    localparam logic [7:0] OP_NOP    = 8'h00;
    localparam logic [7:0] OP_EX_AF  = 8'h08;
    localparam logic [7:0] OP_DJNZ   = 8'h10;
    localparam logic [7:0] OP_JR     = 8'h18;
    localparam logic [7:0] OP_HALT   = 8'h76;
    localparam logic [7:0] OP_RET    = 8'hC9;
    localparam logic [7:0] OP_JP     = 8'hC3;
    localparam logic [7:0] OP_CALL   = 8'hCD;
    localparam logic [7:0] OP_JP_IND = 8'hE9;

    // opcode group masks and patterns
    localparam logic [7:0] MASK_BLOCK = 8'hF4;
    localparam logic [7:0] PAT_BLOCK  = 8'hB0;
    localparam logic [7:0] MASK_GRP   = 8'hC7;
    localparam logic [7:0] PAT_RETN   = 8'h45;
    localparam logic [7:0] PAT_RET_CC = 8'hC0;
    localparam logic [7:0] PAT_JP_CC  = 8'hC2;
    localparam logic [7:0] PAT_CALL_CC = 8'hC4;
    localparam logic [7:0] PAT_RST    = 8'hC7;
    localparam logic [7:0] PAT_REL    = 8'h00;
    localparam logic [7:0] MASK_CC    = 8'hC1;
    localparam logic [7:0] PAT_CC     = 8'hC0;
    localparam logic [7:0] MASK_RST_VEC = 8'h38;

    // interrupt entry
    localparam logic [15:0] INT_ENTRY_IM01 = 16'h0038;
    localparam logic [1:0]  IM_MODE2       = 2'd2;

    // flag bits
    localparam int unsigned FLAG_C  = 0;
    localparam int unsigned FLAG_PV = 2;
    localparam int unsigned FLAG_Z  = 6;
    localparam int unsigned FLAG_S  = 7;

    typedef struct packed {
        logic [47:0] code_bytes;
        logic [15:0] pc_value;
        logic [15:0] hl_value;
        logic [15:0] ix_value;
        logic [15:0] iy_value;
        logic [7:0]  flag_byte;
        logic [7:0]  b_value;
        logic [1:0]  interrupt_mode;
        logic [15:0] stack_word;
        logic [15:0] vector_word;
    } t_item;

    typedef struct packed {
        logic        is_branch;
        logic        target_from_data;
        logic        is_loop;
        logic        is_call;
        logic        is_block;
        logic        is_halt;
        logic [15:0] target;
    } t_result;

    // condition selected by idx (nz/z, nc/c, po/pe, p/m); op bit 3 picks polarity
    function automatic logic cond_true(input logic [7:0] op, input logic [1:0] idx,
                                       input logic [7:0] f);
        logic flag;
        case (idx)
            2'd0:    flag = f[FLAG_Z];
            2'd1:    flag = f[FLAG_C];
            2'd2:    flag = f[FLAG_PV];
            2'd3:    flag = f[FLAG_S];
            default: flag = 1'b0;
        endcase
        return op[3] ? flag : ~flag;
    endfunction

endpackage

/* design/znpp_decode.sv */
// combinational decode of one instruction snapshot into a next-pc prediction
// depends on znpp_pkg (t_item, t_result, opcode constants, cond_true)
module znpp_decode (
    input  znpp_pkg::t_item   i_item,
    output znpp_pkg::t_result o_result
);

    logic [7:0]  op;
    logic [7:0]  cur;
    logic [7:0]  disp;
    logic [15:0] base;
    logic [15:0] imm;
    logic [15:0] rel_tgt;
    logic        ed;
    logic        pre;
    logic        stop;

    // prefix skip: at most four dependent narrow steps
    always_comb begin
        op   = i_item.code_bytes[7:0];
        base = i_item.hl_value;
        ed   = 1'b0;
        pre  = 1'b0;
        stop = 1'b0;
        cur  = '0;
        for (int k = 0; k < znpp_pkg::PFX_MAX; k++) begin
            cur = i_item.code_bytes[8*k +: 8];
            if (!stop) begin
                op = cur;
                if (cur == znpp_pkg::PFX_DD) begin
                    base = i_item.ix_value;
                    pre  = 1'b1;
                end else if (cur == znpp_pkg::PFX_FD) begin
                    base = i_item.iy_value;
                    pre  = 1'b1;
                end else if (cur == znpp_pkg::PFX_CB) begin
                    pre  = 1'b1;
                end else if (cur == znpp_pkg::PFX_ED) begin
                    ed   = 1'b1;
                    pre  = 1'b1;
                end else begin
                    stop = 1'b1;
                end
            end
        end
    end

    assign imm     = i_item.code_bytes[23:8];
    assign disp    = i_item.code_bytes[15:8];
    assign rel_tgt = i_item.pc_value + 16'd2 + {{8{disp[7]}}, disp};

    always_comb begin
        o_result = '0;
        if (ed) begin
            if ((op & znpp_pkg::MASK_BLOCK) == znpp_pkg::PAT_BLOCK) begin
                o_result.is_block = 1'b1;
            end else if ((op & znpp_pkg::MASK_GRP) == znpp_pkg::PAT_RETN) begin
                o_result.is_branch        = 1'b1;
                o_result.target_from_data = 1'b1;
                o_result.target           = i_item.stack_word;
            end
        end else if (op == znpp_pkg::OP_JP_IND) begin
            o_result.is_branch        = 1'b1;
            o_result.target_from_data = 1'b1;
            o_result.target           = base;
        end else if (!pre) begin
            if (op == znpp_pkg::OP_HALT) begin
                o_result.is_halt = 1'b1;
                o_result.target  = (i_item.interrupt_mode < znpp_pkg::IM_MODE2)
                                 ? znpp_pkg::INT_ENTRY_IM01 : i_item.vector_word;
            end else if (op == znpp_pkg::OP_RET) begin
                o_result.is_branch        = 1'b1;
                o_result.target_from_data = 1'b1;
                o_result.target           = i_item.stack_word;
            end else if (op == znpp_pkg::OP_JP) begin
                o_result.is_branch = 1'b1;
                o_result.target    = imm;
            end else if (op == znpp_pkg::OP_CALL) begin
                o_result.is_branch = 1'b1;
                o_result.is_call   = 1'b1;
                o_result.target    = imm;
            end else if ((op & znpp_pkg::MASK_CC) == znpp_pkg::PAT_CC) begin
                if (znpp_pkg::cond_true(op, op[5:4], i_item.flag_byte)) begin
                    if ((op & znpp_pkg::MASK_GRP) == znpp_pkg::PAT_RET_CC) begin
                        o_result.is_branch        = 1'b1;
                        o_result.target_from_data = 1'b1;
                        o_result.target           = i_item.stack_word;
                    end else if ((op & znpp_pkg::MASK_GRP) == znpp_pkg::PAT_CALL_CC) begin
                        o_result.is_branch = 1'b1;
                        o_result.is_call   = 1'b1;
                        o_result.target    = imm;
                    end else if ((op & znpp_pkg::MASK_GRP) == znpp_pkg::PAT_JP_CC) begin
                        o_result.is_branch = 1'b1;
                        o_result.is_loop   = 1'b1;
                        o_result.target    = imm;
                    end
                end
            end else if ((op & znpp_pkg::MASK_GRP) == znpp_pkg::PAT_RST) begin
                o_result.is_branch = 1'b1;
                o_result.is_call   = 1'b1;
                o_result.target    = {8'h00, op & znpp_pkg::MASK_RST_VEC};
            end else if ((op & znpp_pkg::MASK_GRP) == znpp_pkg::PAT_REL) begin
                if (op == znpp_pkg::OP_NOP || op == znpp_pkg::OP_EX_AF) begin
                    o_result = '0;
                end else if (op == znpp_pkg::OP_JR) begin
                    o_result.is_branch = 1'b1;
                    o_result.target    = rel_tgt;
                end else if (op == znpp_pkg::OP_DJNZ) begin
                    if (i_item.b_value != 8'd1) begin
                        o_result.is_branch = 1'b1;
                        o_result.is_loop   = 1'b1;
                        o_result.target    = rel_tgt;
                    end
                end else if (znpp_pkg::cond_true(op, {1'b0, op[4]}, i_item.flag_byte)) begin
                    o_result.is_branch = 1'b1;
                    o_result.is_loop   = 1'b1;
                    o_result.target    = rel_tgt;
                end
            end
        end
    end

endmodule

/* design/z80_next_pc_predictor_top.sv */
// top level of the z80 next-pc predictor: input register, decode, result register
// depends on znpp_pkg and znpp_decode
//
// Takes one snapshot of a z80 instruction (six code bytes at pc plus the registers
// that steer control flow) per beat and returns exactly one prediction beat for it:
// branch, kind flags and a 16-bit target, or all zeros when nothing is predicted.
// Up to three dd/fd/cb/ed prefixes before the opcode are skipped; relative targets
// wrap at 16 bits and djnz counts as taken whenever b is not 1. Throughput is one
// beat per clock with no bubbles while i_out_ready stays high. A beat passes through
// the input register, then the decode that sits between the input and result
// registers, and o_out_valid rises once the result register holds it.
// There is no kept state, so beats are fully independent. The
// input ready is high whenever the input register is empty or moving on, so a new
// beat is taken while a finished result still waits at the output; it depends
// combinationally on i_out_ready through the two-register pipe.
module z80_next_pc_predictor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [47:0] i_code_bytes,
    input  logic [15:0] i_pc_value,
    input  logic [15:0] i_hl_value,
    input  logic [15:0] i_ix_value,
    input  logic [15:0] i_iy_value,
    input  logic [7:0]  i_flag_byte,
    input  logic [7:0]  i_b_value,
    input  logic [1:0]  i_interrupt_mode,
    input  logic [15:0] i_stack_word,
    input  logic [15:0] i_vector_word,

    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_is_branch,
    output logic        o_target_from_data,
    output logic        o_is_loop,
    output logic        o_is_call,
    output logic        o_is_block,
    output logic        o_is_halt,
    output logic [15:0] o_target
);

    // pipe registers
    logic               r_s1_vld;
    znpp_pkg::t_item    r_item;
    logic               r_out_vld;
    znpp_pkg::t_result  r_res;

    logic               n_s1_vld;
    logic               n_out_vld;
    logic               s1_en;
    logic               s2_en;
    znpp_pkg::t_item    in_item;
    znpp_pkg::t_result  dec_res;

    // pack the input beat
    always_comb begin
        in_item.code_bytes     = i_code_bytes;
        in_item.pc_value       = i_pc_value;
        in_item.hl_value       = i_hl_value;
        in_item.ix_value       = i_ix_value;
        in_item.iy_value       = i_iy_value;
        in_item.flag_byte      = i_flag_byte;
        in_item.b_value        = i_b_value;
        in_item.interrupt_mode = i_interrupt_mode;
        in_item.stack_word     = i_stack_word;
        in_item.vector_word    = i_vector_word;
    end

    // result register can load when empty or being drained this cycle
    assign s2_en = !r_out_vld || i_out_ready;
    // input register can load when empty or handing its beat to the result register
    assign s1_en = !r_s1_vld || s2_en;

    assign o_in_ready = s1_en;

    always_comb begin
        n_s1_vld  = s1_en ? i_in_valid : r_s1_vld;
        n_out_vld = s2_en ? r_s1_vld : r_out_vld;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (s1_en && i_in_valid) begin
            r_item <= in_item;
        end
        if (s2_en && r_s1_vld) begin
            r_res <= dec_res;
        end
    end

    // instruction decode between the two registers
    znpp_decode u_decode (
        .i_item   (r_item),
        .o_result (dec_res)
    );

    assign o_out_valid        = r_out_vld;
    assign o_is_branch        = r_res.is_branch;
    assign o_target_from_data = r_res.target_from_data;
    assign o_is_loop          = r_res.is_loop;
    assign o_is_call          = r_res.is_call;
    assign o_is_block         = r_res.is_block;
    assign o_is_halt          = r_res.is_halt;
    assign o_target           = r_res.target;

`ifndef SYNTH
    // an accepted beat always lands in the input register
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_s1_vld)
        else $error("accepted beat not held in input register");

    // a beat in the input register reaches the output when the output is free
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && (!r_out_vld || i_out_ready) |=> r_out_vld)
        else $error("input beat lost on the way to the output");

    // kind flags are mutually exclusive
    a_kind_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $onehot0({r_res.is_loop, r_res.is_call, r_res.is_block,
                                r_res.is_halt, r_res.target_from_data}))
        else $error("more than one kind flag set");

    // block and halt never branch; block carries no target
    a_no_branch_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_res.is_block || r_res.is_halt) |->
            !r_res.is_branch && (r_res.is_halt || r_res.target == 16'h0000))
        else $error("block or halt result marked as branch");

    // every other kind flag implies a branch
    a_kind_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_res.is_loop || r_res.is_call || r_res.target_from_data) |->
            r_res.is_branch)
        else $error("transfer kind without branch");
`endif

endmodule

/* verif/tb_top.sv */
// self-checking testbench for z80_next_pc_predictor_top: directed and random beats
// depends on znpp_pkg for the item/result types and the opcode constants
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // watchdog: cycles with no beat on either channel before the run is abandoned
    localparam int unsigned STALL_LIMIT = 2000;
    // random beats after the directed part
    localparam int unsigned NUM_RANDOM  = 1900;
    // results seen before the receiver's long hold-off starts
    localparam int unsigned HOLD_AT     = 500;
    localparam int unsigned HOLD_CYCLES = 300;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // input channel, payload held in one struct and fanned out to the ports
    logic            in_valid = 1'b0;
    znpp_pkg::t_item drv_item = '0;
    logic            o_in_ready;

    // output channel
    logic        out_ready = 1'b0;
    logic        o_out_valid;
    logic        o_is_branch;
    logic        o_target_from_data;
    logic        o_is_loop;
    logic        o_is_call;
    logic        o_is_block;
    logic        o_is_halt;
    logic [15:0] o_target;

    // instruction snapshots waiting to be driven, predictions waiting for their beat
    znpp_pkg::t_item   instr_q[$];
    znpp_pkg::t_result predicted_q[$];

    int mismatch_cnt  = 0;
    int results_seen  = 0;
    int gap_cnt       = 0;
    int stall_cnt     = 0;
    int idle_cycles   = 0;
    bit in_burst      = 1'b0;
    bit out_burst     = 1'b0;
    bit long_hold_done = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    z80_next_pc_predictor_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_code_bytes       (drv_item.code_bytes),
        .i_pc_value         (drv_item.pc_value),
        .i_hl_value         (drv_item.hl_value),
        .i_ix_value         (drv_item.ix_value),
        .i_iy_value         (drv_item.iy_value),
        .i_flag_byte        (drv_item.flag_byte),
        .i_b_value          (drv_item.b_value),
        .i_interrupt_mode   (drv_item.interrupt_mode),
        .i_stack_word       (drv_item.stack_word),
        .i_vector_word      (drv_item.vector_word),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_is_branch        (o_is_branch),
        .o_target_from_data (o_target_from_data),
        .o_is_loop          (o_is_loop),
        .o_is_call          (o_is_call),
        .o_is_block         (o_is_block),
        .o_is_halt          (o_is_halt),
        .o_target           (o_target)
    );

    // ------------------------------------------------------------------
    // next-pc prediction for one snapshot
    // ------------------------------------------------------------------
    function automatic znpp_pkg::t_result predict_next_pc(input znpp_pkg::t_item it);
        znpp_pkg::t_result res;
        logic [7:0]  op;
        logic [15:0] jp_ind_reg;
        logic [15:0] rel_dest;
        logic [3:0]  cc_flags;
        logic        seen_ed;
        logic        seen_pfx;
        logic        scanning;
        logic        cc_holds;
        int          k;

        res        = '0;
        op         = 8'h00;
        jp_ind_reg = it.hl_value;
        seen_ed    = 1'b0;
        seen_pfx   = 1'b0;
        scanning   = 1'b1;

        // walk the prefix window; the last dd/fd decides which pair jp (hl) uses
        for (k = 0; k < znpp_pkg::PFX_MAX; k++) begin
            if (scanning) begin
                op = it.code_bytes[8*k +: 8];
                if (op == znpp_pkg::PFX_DD) begin
                    jp_ind_reg = it.ix_value;
                    seen_pfx   = 1'b1;
                end else if (op == znpp_pkg::PFX_FD) begin
                    jp_ind_reg = it.iy_value;
                    seen_pfx   = 1'b1;
                end else if (op == znpp_pkg::PFX_CB) begin
                    seen_pfx = 1'b1;
                end else if (op == znpp_pkg::PFX_ED) begin
                    seen_ed  = 1'b1;
                    seen_pfx = 1'b1;
                end else begin
                    scanning = 1'b0;
                end
            end
        end

        // flags indexed by the cc field: nz/z, nc/c, po/pe, p/m
        cc_flags = {it.flag_byte[znpp_pkg::FLAG_S], it.flag_byte[znpp_pkg::FLAG_PV],
                    it.flag_byte[znpp_pkg::FLAG_C], it.flag_byte[znpp_pkg::FLAG_Z]};
        rel_dest = it.pc_value + 16'd2 + {{8{it.code_bytes[15]}}, it.code_bytes[15:8]};

        if (seen_ed) begin
            if ((op & znpp_pkg::MASK_BLOCK) == znpp_pkg::PAT_BLOCK) begin
                res.is_block = 1'b1;
            end else if ((op & znpp_pkg::MASK_GRP) == znpp_pkg::PAT_RETN) begin
                res.is_branch        = 1'b1;
                res.target_from_data = 1'b1;
                res.target           = it.stack_word;
            end
        end else if (op == znpp_pkg::OP_JP_IND) begin
            res.is_branch        = 1'b1;
            res.target_from_data = 1'b1;
            res.target           = jp_ind_reg;
        end else if (!seen_pfx) begin
            if (op == znpp_pkg::OP_HALT) begin
                res.is_halt = 1'b1;
                res.target  = (it.interrupt_mode < znpp_pkg::IM_MODE2)
                            ? znpp_pkg::INT_ENTRY_IM01 : it.vector_word;
            end else if (op == znpp_pkg::OP_RET) begin
                res.is_branch        = 1'b1;
                res.target_from_data = 1'b1;
                res.target           = it.stack_word;
            end else if (op == znpp_pkg::OP_JP || op == znpp_pkg::OP_CALL) begin
                res.is_branch = 1'b1;
                res.is_call   = (op == znpp_pkg::OP_CALL);
                res.target    = it.code_bytes[23:8];
            end else if ((op & znpp_pkg::MASK_CC) == znpp_pkg::PAT_CC) begin
                // op bit 3 picks the polarity of the selected flag
                cc_holds = (cc_flags[op[5:4]] == op[3]);
                if (cc_holds && (op & znpp_pkg::MASK_GRP) == znpp_pkg::PAT_RET_CC) begin
                    res.is_branch        = 1'b1;
                    res.target_from_data = 1'b1;
                    res.target           = it.stack_word;
                end else if (cc_holds
                             && (op & znpp_pkg::MASK_GRP) == znpp_pkg::PAT_CALL_CC) begin
                    res.is_branch = 1'b1;
                    res.is_call   = 1'b1;
                    res.target    = it.code_bytes[23:8];
                end else if (cc_holds
                             && (op & znpp_pkg::MASK_GRP) == znpp_pkg::PAT_JP_CC) begin
                    res.is_branch = 1'b1;
                    res.is_loop   = 1'b1;
                    res.target    = it.code_bytes[23:8];
                end
            end else if ((op & znpp_pkg::MASK_GRP) == znpp_pkg::PAT_RST) begin
                res.is_branch = 1'b1;
                res.is_call   = 1'b1;
                res.target    = {8'h00, op & znpp_pkg::MASK_RST_VEC};
            end else if ((op & znpp_pkg::MASK_GRP) == znpp_pkg::PAT_REL
                         && op != znpp_pkg::OP_NOP && op != znpp_pkg::OP_EX_AF) begin
                if (op == znpp_pkg::OP_JR) begin
                    res.is_branch = 1'b1;
                    res.target    = rel_dest;
                end else if (op == znpp_pkg::OP_DJNZ) begin
                    // taken unless this decrement brings b to zero
                    if (it.b_value != 8'd1) begin
                        res.is_branch = 1'b1;
                        res.is_loop   = 1'b1;
                        res.target    = rel_dest;
                    end
                end else if (cc_flags[{1'b0, op[4]}] == op[3]) begin
                    res.is_branch = 1'b1;
                    res.is_loop   = 1'b1;
                    res.target    = rel_dest;
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // register file around an instruction: random, with pc near the wrap and
    // b around the djnz boundary more often than chance
    function automatic znpp_pkg::t_item random_regs();
        znpp_pkg::t_item it;
        it.code_bytes     = 48'({$urandom(), $urandom()});
        it.pc_value       = 16'($urandom());
        if ($urandom_range(0, 7) == 0)
            it.pc_value = 16'hFF80 + 16'($urandom_range(0, 255));
        it.hl_value       = 16'($urandom());
        it.ix_value       = 16'($urandom());
        it.iy_value       = 16'($urandom());
        it.flag_byte      = 8'($urandom());
        case ($urandom_range(0, 7))
            0, 1:    it.b_value = 8'd1;
            2:       it.b_value = 8'd0;
            default: it.b_value = 8'($urandom());
        endcase
        it.interrupt_mode = 2'($urandom_range(0, 3));
        it.stack_word     = 16'($urandom());
        it.vector_word    = 16'($urandom());
        return it;
    endfunction

    // opcode and two operand bytes at pc, random bytes behind them
    function automatic logic [47:0] code3(input logic [7:0] op, input logic [7:0] b1,
                                          input logic [7:0] b2);
        return {24'($urandom()), b2, b1, op};
    endfunction

    // mostly well-formed instructions from every decoded group, some noise
    function automatic znpp_pkg::t_item random_instr();
        znpp_pkg::t_item it;
        logic [7:0] pfx_set[4];
        logic [7:0] op;
        int         n_pfx;
        int         grp;
        int         k;

        it         = random_regs();
        pfx_set[0] = znpp_pkg::PFX_DD;
        pfx_set[1] = znpp_pkg::PFX_FD;
        pfx_set[2] = znpp_pkg::PFX_CB;
        pfx_set[3] = znpp_pkg::PFX_ED;
        grp        = $urandom_range(0, 19);
        op         = 8'($urandom());

        case (grp)
            0, 1, 2, 3: op = znpp_pkg::PAT_REL | (op & ~znpp_pkg::MASK_GRP);
            4, 5, 6, 7: op = znpp_pkg::PAT_CC | (op & ~znpp_pkg::MASK_CC);
            8, 9:       op = znpp_pkg::PAT_RST | (op & znpp_pkg::MASK_RST_VEC);
            10:         op = znpp_pkg::OP_HALT;
            11:         op = znpp_pkg::OP_RET;
            12:         op = znpp_pkg::OP_JP;
            13:         op = znpp_pkg::OP_CALL;
            14, 15:     op = znpp_pkg::OP_JP_IND;
            16:         op = znpp_pkg::PAT_BLOCK | (op & ~znpp_pkg::MASK_BLOCK);
            17:         op = znpp_pkg::PAT_RETN | (op & ~znpp_pkg::MASK_GRP);
            default:    ;
        endcase

        // ed forms need an ed ahead of them; otherwise prefixes are occasional
        n_pfx = ($urandom_range(0, 3) == 0) ? $urandom_range(1, znpp_pkg::PFX_MAX) : 0;
        if ((grp == 16 || grp == 17) && $urandom_range(0, 7) != 0 && n_pfx == 0)
            n_pfx = 1;
        for (k = 0; k < n_pfx; k++)
            it.code_bytes[8*k +: 8] = pfx_set[2'($urandom_range(0, 3))];
        if ((grp == 16 || grp == 17) && n_pfx > 0 && n_pfx < znpp_pkg::PFX_MAX)
            it.code_bytes[8*(n_pfx-1) +: 8] = znpp_pkg::PFX_ED;
        if (n_pfx < znpp_pkg::PFX_MAX && grp != 19)
            it.code_bytes[8*n_pfx +: 8] = op;
        return it;
    endfunction

    // gap or stall length: mostly short, a few long
    function automatic int idle_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 0;
        if (sel < 90)
            return $urandom_range(1, 3);
        if (sel < 99)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(input string fname, input logic [15:0] expv,
                               input logic [15:0] actv);
        if (expv != actv) begin
            mismatch_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, expv, actv);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: offers queued snapshots, predicts each one as its beat is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready)
                predicted_q.push_back(predict_next_pc(drv_item));
            // payload may only change once the held beat is gone
            if (!in_valid || o_in_ready) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                    in_valid <= 1'b0;
                end else if (instr_q.size() > 0) begin
                    drv_item <= instr_q.pop_front();
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 199) == 0)
                        in_burst = !in_burst;
                    gap_cnt = in_burst ? 0 : idle_len();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result beat against the oldest prediction and
    // throttles the output side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                results_seen++;
                if (predicted_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: result beat with no prediction waiting, actual %b%b%b%b%b%b %0h",
                             $time, o_is_branch, o_target_from_data, o_is_loop, o_is_call,
                             o_is_block, o_is_halt, o_target);
                end else begin
                    znpp_pkg::t_result exp_res;
                    exp_res = predicted_q.pop_front();
                    check_field("is_branch", 16'(exp_res.is_branch), 16'(o_is_branch));
                    check_field("target_from_data", 16'(exp_res.target_from_data),
                                16'(o_target_from_data));
                    check_field("is_loop", 16'(exp_res.is_loop), 16'(o_is_loop));
                    check_field("is_call", 16'(exp_res.is_call), 16'(o_is_call));
                    check_field("is_block", 16'(exp_res.is_block), 16'(o_is_block));
                    check_field("is_halt", 16'(exp_res.is_halt), 16'(o_is_halt));
                    check_field("target", exp_res.target, o_target);
                end
            end

            // one long hold-off so both pipe stages fill and input ready drops
            if (results_seen >= HOLD_AT && !long_hold_done) begin
                long_hold_done = 1'b1;
                stall_cnt      = HOLD_CYCLES;
            end

            if (stall_cnt > 0) begin
                stall_cnt--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 199) == 0)
                    out_burst = !out_burst;
                if (!out_burst && $urandom_range(0, 3) == 0)
                    stall_cnt = idle_len();
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("z80_next_pc_predictor_top regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        znpp_pkg::t_item d;
        int              k;
        int              n_items;

        // directed: field extremes, every decoded group, prefix corner cases
        d = '0;                                              // nop, everything zero
        instr_q.push_back(d);
        d = '1;                                              // rst 38h, all ones
        instr_q.push_back(d);
        for (k = 0; k < 4; k++) begin                        // halt in every mode
            d = random_regs();
            d.code_bytes     = code3(znpp_pkg::OP_HALT, 8'h00, 8'h00);
            d.interrupt_mode = 2'(k);
            instr_q.push_back(d);
        end
        d = random_regs(); d.code_bytes = code3(znpp_pkg::OP_RET, 8'h00, 8'h00);
        instr_q.push_back(d);
        d = random_regs(); d.code_bytes = code3(znpp_pkg::OP_JP, 8'hFF, 8'hFF);
        instr_q.push_back(d);
        d = random_regs(); d.code_bytes = code3(znpp_pkg::OP_CALL, 8'h34, 8'h12);
        instr_q.push_back(d);
        d = random_regs(); d.code_bytes = code3(8'hC0, 8'h00, 8'h00);  // ret nz, taken
        d.flag_byte = 8'h00;
        instr_q.push_back(d);
        d = random_regs(); d.code_bytes = code3(8'hC8, 8'h00, 8'h00);  // ret z, not taken
        d.flag_byte = 8'h00;
        instr_q.push_back(d);
        d = random_regs(); d.code_bytes = code3(8'hFA, 8'h00, 8'h80);  // jp m, taken
        d.flag_byte = 8'h80;
        instr_q.push_back(d);
        d = random_regs(); d.code_bytes = code3(8'hEC, 8'h55, 8'hAA);  // call pe, taken
        d.flag_byte = 8'h04;
        instr_q.push_back(d);
        // jr with the most negative displacement at pc 0 wraps below zero
        d = random_regs(); d.code_bytes = code3(znpp_pkg::OP_JR, 8'h80, 8'h00);
        d.pc_value = 16'h0000;
        instr_q.push_back(d);
        // jr with the most positive displacement at the top of memory wraps past it
        d = random_regs(); d.code_bytes = code3(znpp_pkg::OP_JR, 8'h7F, 8'h00);
        d.pc_value = 16'hFFFF;
        instr_q.push_back(d);
        d = random_regs(); d.code_bytes = code3(znpp_pkg::OP_DJNZ, 8'hFE, 8'h00);  // b = 1
        d.b_value = 8'd1;
        instr_q.push_back(d);
        d = random_regs(); d.code_bytes = code3(znpp_pkg::OP_DJNZ, 8'hFE, 8'h00);  // b = 0
        d.b_value = 8'd0;
        instr_q.push_back(d);
        d = random_regs(); d.code_bytes = code3(8'h38, 8'h10, 8'h00);    // jr c, taken
        d.flag_byte = 8'h01;
        instr_q.push_back(d);
        d = random_regs(); d.code_bytes = code3(znpp_pkg::OP_JP_IND, 8'h00, 8'h00);
        instr_q.push_back(d);
        d = random_regs();
        d.code_bytes = code3(znpp_pkg::PFX_DD, znpp_pkg::OP_JP_IND, 8'h00);
        instr_q.push_back(d);
        // last index prefix wins: dd fd jp (hl) goes through iy
        d = random_regs();
        d.code_bytes = code3(znpp_pkg::PFX_DD, znpp_pkg::PFX_FD, znpp_pkg::OP_JP_IND);
        instr_q.push_back(d);
        d = random_regs();                                                  // ldir
        d.code_bytes = code3(znpp_pkg::PFX_ED, znpp_pkg::PAT_BLOCK, 8'h00);
        instr_q.push_back(d);
        d = random_regs(); d.code_bytes = code3(znpp_pkg::PFX_ED, 8'h4D, 8'h00);  // reti
        instr_q.push_back(d);
        // four prefixes leave no opcode inside the window
        d = random_regs();
        d.code_bytes = {8'h00, znpp_pkg::OP_JP_IND, {4{znpp_pkg::PFX_DD}}};
        instr_q.push_back(d);
        // prefixed opcode that only predicts unprefixed: no prediction
        d = random_regs();
        d.code_bytes = code3(znpp_pkg::PFX_CB, znpp_pkg::OP_RET, 8'h00);
        instr_q.push_back(d);
        d = random_regs(); d.code_bytes = code3(znpp_pkg::OP_EX_AF, 8'h00, 8'h00);
        instr_q.push_back(d);

        for (k = 0; k < NUM_RANDOM; k++)
            instr_q.push_back(random_instr());
        n_items = instr_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: every snapshot answered by a result beat, the watchdog ends a stuck run
        while (results_seen < n_items)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (predicted_q.size() != 0) begin
            mismatch_cnt++;
            $display("%0t: %0d predictions never matched by a result beat",
                     $time, predicted_q.size());
        end
        if (mismatch_cnt == 0) begin
            $display("z80_next_pc_predictor_top regression: pass");
        end else begin
            $display("z80_next_pc_predictor_top regression: fail");
        end
        $finish;
    end

endmodule
